### design/assert_macros.svh
// Assertion macros shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
// Condition in one cycle implies the result in the next.
`define ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, cond)
`define ASSERT_NEXT(label, pre, post)
`endif
`endif

### design/prd_pkg.sv
// Shared types and register codes for the packet receive deframer.
package prd_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_HEAD_BYTE   = 3'd0;
	localparam logic [2:0] REG_TAIL_BYTE   = 3'd1;
	localparam logic [2:0] REG_LEDS_SET_ID = 3'd2;
	localparam logic [2:0] REG_LEDS_GET_ID = 3'd3;
	localparam logic [2:0] REG_PING_ID     = 3'd4;

	// Reset values of the configuration registers
	localparam logic [7:0] HEAD_BYTE_RST   = 8'd204;
	localparam logic [7:0] TAIL_BYTE_RST   = 8'd185;
	localparam logic [7:0] LEDS_SET_ID_RST = 8'd130;
	localparam logic [7:0] LEDS_GET_ID_RST = 8'd131;
	localparam logic [7:0] PING_ID_RST     = 8'd132;

	typedef struct packed {
		logic [7:0] head_byte;
		logic [7:0] tail_byte;
		logic [7:0] leds_set_id;
		logic [7:0] leds_get_id;
		logic [7:0] ping_id;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  event_code;
		logic [7:0]  msg_length;
		logic [7:0]  msg_id;
		logic [7:0]  first_payload;
		logic [7:0]  led_state;
		logic [31:0] pong_value;
	} res_t;

endpackage

### design/packet_receive_deframer.sv
// Top level of the packet receive deframer: config registers, parser, result queue.
//
// Usage:
//   Bytes of the serial stream enter on in_valid/in_ready/rx_byte, one request
//   per byte. Frames are head, length, id, payload, tail, checksum; bytes outside
//   a frame are dropped. A packet end yields one result request on out_valid/
//   out_ready carrying event_code, msg_length, msg_id, first_payload, led_state
//   and pong_value.
//   Throughput is one byte per cycle while in_ready is high: the parser state
//   updates at the edge that accepts a byte, and the result enters the queue
//   at the edge that takes the checksum or a bad tail byte.
//   Results wait in a two-entry queue. While the receiver stalls, bytes keep
//   flowing until both entries hold results; in_ready then drops until one is
//   taken.
//   Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data, always
//   ready; index 0 head, 1 tail, 2 leds-set id, 3 leds-get id, 4 ping id, other
//   indexes are ignored. Write them only while the block is idle.
//   Reset clears the parser, the LED register and the queue and restores the
//   default register values.
module packet_receive_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_code,
	output logic [7:0]  msg_length,
	output logic [7:0]  msg_id,
	output logic [7:0]  first_payload,
	output logic [7:0]  led_state,
	output logic [31:0] pong_value
);
	import prd_pkg::*;

	cfg_t cfg_q;
	logic acc;
	logic res_valid;
	res_t res;
	res_t out_res;
	logic full;

	assign cfg_ready = 1'b1;
	assign in_ready  = !full;
	assign acc       = in_valid && in_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_byte   <= HEAD_BYTE_RST;
			cfg_q.tail_byte   <= TAIL_BYTE_RST;
			cfg_q.leds_set_id <= LEDS_SET_ID_RST;
			cfg_q.leds_get_id <= LEDS_GET_ID_RST;
			cfg_q.ping_id     <= PING_ID_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HEAD_BYTE:   cfg_q.head_byte   <= cfg_data;
				REG_TAIL_BYTE:   cfg_q.tail_byte   <= cfg_data;
				REG_LEDS_SET_ID: cfg_q.leds_set_id <= cfg_data;
				REG_LEDS_GET_ID: cfg_q.leds_get_id <= cfg_data;
				REG_PING_ID:     cfg_q.ping_id     <= cfg_data;
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	prd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.acc       (acc),
		.rx_byte   (rx_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	prd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc && res_valid),
		.push_data (res),
		.full      (full),
		.pop_valid (out_valid),
		.pop_ready (out_ready),
		.pop_data  (out_res)
	);

	assign event_code    = out_res.event_code;
	assign msg_length    = out_res.msg_length;
	assign msg_id        = out_res.msg_id;
	assign first_payload = out_res.first_payload;
	assign led_state     = out_res.led_state;
	assign pong_value    = out_res.pong_value;

endmodule

### design/prd_parser.sv
// Frame parser: phase tracking, checksum, LED register and event decode.
`include "assert_macros.svh"
module prd_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  prd_pkg::cfg_t cfg,
	input  logic          acc,
	input  logic [7:0]    rx_byte,
	output logic          res_valid,
	output prd_pkg::res_t res
);
	import prd_pkg::*;

	localparam logic [2:0] PH_HEAD    = 3'd0;
	localparam logic [2:0] PH_LENGTH  = 3'd1;
	localparam logic [2:0] PH_ID      = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_TAIL    = 3'd4;
	localparam logic [2:0] PH_CHECK   = 3'd5;

	localparam logic [2:0] EV_TAIL_ERR   = 3'd0;
	localparam logic [2:0] EV_SUM_ERR    = 3'd1;
	localparam logic [2:0] EV_LEDS_SET   = 3'd2;
	localparam logic [2:0] EV_LEDS_STATE = 3'd3;
	localparam logic [2:0] EV_PONG       = 3'd4;
	localparam logic [2:0] EV_DELIVERED  = 3'd5;

	localparam logic [7:0] PING_BYTES = 8'd4;

	logic [2:0]  phase_q, phase_n;
	logic [7:0]  len_q, len_n;
	logic [7:0]  id_q, id_n;
	logic [7:0]  sum_q, sum_n;
	logic [7:0]  cnt_q, cnt_n;
	logic [7:0]  pend_q, pend_n;
	logic [7:0]  led_q, led_n;
	logic [31:0] word_q, word_n;
	logic [7:0]  first_q, first_n;
	logic        ping_q, ping_n;

	logic [7:0]  sum_add;
	logic [7:0]  eff_len;
	logic [7:0]  cnt_inc;

	// Rotate right by one, then add the byte
	assign sum_add = {sum_q[0], sum_q[7:1]} + rx_byte;
	// A zero length field counts as one payload byte
	assign eff_len = (len_q == 8'd0) ? 8'd1 : len_q;
	assign cnt_inc = cnt_q + 8'd1;

	// Next state and event decode for the byte on the input
	always_comb begin
		phase_n = phase_q;
		len_n   = len_q;
		id_n    = id_q;
		sum_n   = sum_q;
		cnt_n   = cnt_q;
		pend_n  = pend_q;
		led_n   = led_q;
		word_n  = word_q;
		first_n = first_q;
		ping_n  = ping_q;

		res_valid         = 1'b0;
		res.event_code    = EV_TAIL_ERR;
		res.msg_length    = len_q;
		res.msg_id        = id_q;
		res.first_payload = 8'd0;
		res.led_state     = led_q;
		res.pong_value    = 32'd0;

		case (phase_q)
			PH_LENGTH: begin
				len_n   = rx_byte;
				phase_n = PH_ID;
			end
			PH_ID: begin
				id_n    = rx_byte;
				sum_n   = sum_add;
				phase_n = (rx_byte == cfg.leds_get_id) ? PH_TAIL : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				sum_n = sum_add;
				if (id_q == cfg.leds_set_id && cnt_q == 8'd0) begin
					pend_n  = rx_byte;
					phase_n = PH_TAIL;
				end else if ((id_q == cfg.ping_id && cnt_q == 8'd0) || ping_q) begin
					ping_n = 1'b1;
					word_n = {word_q[23:0], rx_byte};
					cnt_n  = cnt_inc;
					if (cnt_inc >= PING_BYTES)
						phase_n = PH_TAIL;
				end else begin
					if (cnt_q == 8'd0)
						first_n = rx_byte;
					// last byte when count + 1 reaches the length (9 bits, no wrap)
					if (({1'b0, cnt_q} + 9'd1) >= {1'b0, eff_len})
						phase_n = PH_TAIL;
					else
						cnt_n = cnt_inc;
				end
			end
			PH_TAIL: begin
				if (rx_byte != cfg.tail_byte) begin
					res_valid      = 1'b1;
					res.event_code = EV_TAIL_ERR;
					phase_n        = PH_HEAD;
				end else begin
					phase_n = PH_CHECK;
				end
			end
			PH_CHECK: begin
				res_valid = 1'b1;
				phase_n   = PH_HEAD;
				if (rx_byte != sum_q) begin
					res.event_code = EV_SUM_ERR;
				end else if (id_q == cfg.leds_set_id) begin
					led_n          = pend_q;
					res.led_state  = pend_q;
					res.event_code = EV_LEDS_SET;
				end else if (id_q == cfg.leds_get_id) begin
					res.event_code = EV_LEDS_STATE;
				end else if (ping_q) begin
					ping_n         = 1'b0;
					res.event_code = EV_PONG;
					res.pong_value = {1'b0, word_q[31:1]};
				end else begin
					res.event_code    = EV_DELIVERED;
					res.first_payload = first_q;
				end
			end
			default: begin
				// waiting for head; unused codes land here too
				phase_n = PH_HEAD;
				if (rx_byte == cfg.head_byte) begin
					len_n   = 8'd0;
					id_n    = 8'd0;
					sum_n   = 8'd0;
					cnt_n   = 8'd0;
					pend_n  = 8'd0;
					word_n  = 32'd0;
					first_n = 8'd0;
					ping_n  = 1'b0;
					phase_n = PH_LENGTH;
				end
			end
		endcase
	end

	// Parser state, updated on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD;
			len_q   <= 8'd0;
			id_q    <= 8'd0;
			sum_q   <= 8'd0;
			cnt_q   <= 8'd0;
			pend_q  <= 8'd0;
			led_q   <= 8'd0;
			word_q  <= 32'd0;
			first_q <= 8'd0;
			ping_q  <= 1'b0;
		end else if (acc) begin
			phase_q <= phase_n;
			len_q   <= len_n;
			id_q    <= id_n;
			sum_q   <= sum_n;
			cnt_q   <= cnt_n;
			pend_q  <= pend_n;
			led_q   <= led_n;
			word_q  <= word_n;
			first_q <= first_n;
			ping_q  <= ping_n;
		end
	end

	// Events only come out of the tail and checksum phases
	`ASSERT_ALWAYS(a_evt_phase, !(acc && res_valid) || phase_q == PH_TAIL || phase_q == PH_CHECK)
	// Every event sends the parser back to waiting for head
	`ASSERT_NEXT(a_evt_to_head, acc && res_valid, phase_q == PH_HEAD)
	// Ping flag is clear before the payload phase
	`ASSERT_ALWAYS(a_ping_clear, !ping_q || (phase_q != PH_LENGTH && phase_q != PH_ID))

endmodule

### design/prd_out_buf.sv
// Two-entry result queue between the parser and the output channel.
`include "assert_macros.svh"
module prd_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  prd_pkg::res_t push_data,
	output logic          full,
	output logic          pop_valid,
	input  logic          pop_ready,
	output prd_pkg::res_t pop_data
);
	import prd_pkg::*;

	res_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign pop       = pop_valid && pop_ready;
	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data  = slot_q[rd_ptr_q];

	// Result storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_ALWAYS(a_no_overflow, !(push && count_q == 2'd2))
	`ASSERT_ALWAYS(a_count_range, count_q != 2'd3)
	`ASSERT_NEXT(a_push_grows, push && !pop, count_q == $past(count_q) + 2'd1)

endmodule
